FILE: src/bhd_pkg.sv
// Shared types and codes for the button hold duration classifier.
`timescale 1ns / 1ps
`default_nettype none

package bhd_pkg;

  localparam int unsigned TimeW   = 64;
  localparam int unsigned HoldW   = 32;
  localparam int unsigned CfgIdxW = 1;

  // event kinds
  localparam logic [1:0] EV_SHORT   = 2'd0;
  localparam logic [1:0] EV_RESTART = 2'd1;
  localparam logic [1:0] EV_FACTORY = 2'd2;
  localparam logic [1:0] EV_NONE    = 2'd3;

  // LED overlay codes
  localparam logic [1:0] OV_NONE    = 2'd0;
  localparam logic [1:0] OV_RESTART = 2'd1;
  localparam logic [1:0] OV_FACTORY = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_RESTART_HOLD = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_FACTORY_HOLD = 1'd1;

  localparam logic [HoldW-1:0] RESTART_HOLD_RST = 32'd3000;
  localparam logic [HoldW-1:0] FACTORY_HOLD_RST = 32'd10000;

  typedef struct packed {
    logic [HoldW-1:0] restart_hold_ms;
    logic [HoldW-1:0] factory_hold_ms;
  } bhd_cfg_t;

  typedef struct packed {
    logic [1:0] led_overlay;
    logic [1:0] event_kind;
    logic       event_valid;
  } bhd_result_t;

endpackage

`default_nettype wire

FILE: src/bhd_cfg_regs.sv
// Threshold configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module bhd_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bhd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bhd_pkg::HoldW-1:0]    cfg_wdata_i,
  output bhd_pkg::bhd_cfg_t                 cfg_o
);
  import bhd_pkg::*;

  logic [HoldW-1:0] restart_q;
  logic [HoldW-1:0] factory_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q <= RESTART_HOLD_RST;
      factory_q <= FACTORY_HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RESTART_HOLD: restart_q <= cfg_wdata_i;
        REG_FACTORY_HOLD: factory_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.restart_hold_ms = restart_q;
  assign cfg_o.factory_hold_ms = factory_q;

endmodule

`default_nettype wire

FILE: src/bhd_classify.sv
// Hold phase tracking and classification of one sample.
`timescale 1ns / 1ps
`default_nettype none

module bhd_classify (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic                       button_down_i,
  input  wire logic [bhd_pkg::TimeW-1:0]  time_ms_i,
  input  bhd_pkg::bhd_cfg_t               cfg_i,
  output bhd_pkg::bhd_result_t            result_o
);
  import bhd_pkg::*;

  localparam logic [1:0] PH_RELEASED = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_RESTART  = 2'd2;
  localparam logic [1:0] PH_FACTORY  = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [TimeW:0]   diff;
  logic [TimeW-1:0] dur;
  logic             went_back;
  logic             ge_factory;
  logic             ge_restart;

  // one subtract gives both the duration and the time-went-backwards borrow
  assign diff       = {1'b0, time_ms_i} - {1'b0, start_q};
  assign dur        = diff[TimeW-1:0];
  assign went_back  = diff[TimeW];
  assign ge_factory = (dur[TimeW-1:HoldW] != '0) || (dur[HoldW-1:0] >= cfg_i.factory_hold_ms);
  assign ge_restart = (dur[TimeW-1:HoldW] != '0) || (dur[HoldW-1:0] >= cfg_i.restart_hold_ms);

  always_comb begin
    phase_d              = phase_q;
    start_d              = start_q;
    result_o.event_valid = 1'b0;
    result_o.event_kind  = EV_NONE;
    result_o.led_overlay = OV_NONE;
    if (!button_down_i) begin
      if (phase_q != PH_RELEASED) begin
        result_o.event_valid = 1'b1;
        priority if (ge_factory) result_o.event_kind = EV_FACTORY;
        else if (ge_restart)     result_o.event_kind = EV_RESTART;
        else                     result_o.event_kind = EV_SHORT;
        phase_d = PH_RELEASED;
      end
    end else if (phase_q == PH_RELEASED) begin
      phase_d = PH_PRESSED;
      start_d = time_ms_i;
    end else if (went_back) begin
      phase_d = PH_RELEASED;
    end else begin
      if (phase_q == PH_PRESSED || phase_q == PH_RESTART) begin
        if (ge_factory) begin
          phase_d = PH_FACTORY;
        end else if (phase_q == PH_PRESSED && ge_restart) begin
          phase_d = PH_RESTART;
        end
      end
      unique case (phase_d)
        PH_RESTART: result_o.led_overlay = OV_RESTART;
        PH_FACTORY: result_o.led_overlay = OV_FACTORY;
        default:    result_o.led_overlay = OV_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RELEASED;
      start_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/button_hold_duration_classifier.sv
// Top level: input register, classifier and result register.
`timescale 1ns / 1ps
`default_nettype none

// Button hold classifier. Each input item is one sample of the button level
// with a 64-bit millisecond timestamp; each produces exactly one result item
// with the release event (short, restart or factory) and the LED overlay.
// Items pass an input register, the classification logic (a 64-bit subtract
// and two threshold compares) and a result register; a new item is taken
// every cycle while the result side keeps up. The user must write thresholds
// through the cfg port only while no item is in flight; the block does not enforce this.

module button_hold_duration_classifier (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  input  wire logic [71:0]                  s_axis_tdata,  // [0] button_down, [64:1] time_ms
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output      logic [7:0]                   m_axis_tdata,  // [0] event_valid,
                                                           // [2:1] event_kind, [4:3] led_overlay
  input  wire logic                         cfg_we_i,
  input  wire logic [bhd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bhd_pkg::HoldW-1:0]    cfg_wdata_i
);
  import bhd_pkg::*;

  bhd_cfg_t         cfg;
  bhd_result_t      result;
  logic             in_valid_q;
  logic             in_down_q;
  logic [TimeW-1:0] in_time_q;
  logic             out_valid_q;
  bhd_result_t      out_res_q;
  logic             advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_down_q <= s_axis_tdata[0];
      in_time_q <= s_axis_tdata[TimeW:1];
    end
  end

  bhd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bhd_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .button_down_i (in_down_q),
    .time_ms_i     (in_time_q),
    .cfg_i         (cfg),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q};

endmodule

`default_nettype wire

FILE: test/tb.sv
// Testbench for the button hold duration classifier: stream driver, monitor and hold predictor.
`timescale 1ns / 1ps

module tb;
  import bhd_pkg::*;

  localparam int unsigned PhaseItems = 278;
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned IdleLimit  = 3000;

  typedef enum logic [1:0] {
    HOLD_IDLE,
    HOLD_PRESSED,
    HOLD_RESTART,
    HOLD_FACTORY
  } hold_phase_e;

  typedef struct packed {
    logic             down;
    logic [TimeW-1:0] stamp;
  } sample_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic [71:0]       s_axis_tdata  = '0;   // [0] button_down, [64:1] time_ms
  logic              m_axis_tready = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i  = '0;
  logic [HoldW-1:0]  cfg_wdata_i   = '0;
  wire               s_axis_tready;
  wire               m_axis_tvalid;
  wire [7:0]         m_axis_tdata;         // [0] event_valid, [2:1] event_kind, [4:3] led_overlay

  button_hold_duration_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  sample_t     sample_q[$];
  bhd_result_t verdict_q[$];

  // predictor state and its copy of the thresholds
  hold_phase_e      hold_phase  = HOLD_IDLE;
  logic [TimeW-1:0] hold_start  = '0;
  logic [HoldW-1:0] lim_restart = RESTART_HOLD_RST;
  logic [HoldW-1:0] lim_factory = FACTORY_HOLD_RST;

  int unsigned errors = 0;
  int unsigned n_in = 0, n_out = 0;
  int unsigned n_short = 0, n_restart = 0, n_factory = 0;
  int unsigned idle_cycles = 0;

  function automatic bhd_result_t classify_sample(input logic down, input logic [TimeW-1:0] now);
    bhd_result_t r;
    logic [TimeW-1:0] held;
    r.event_valid = 1'b0;
    r.event_kind  = EV_NONE;
    r.led_overlay = OV_NONE;
    held = now - hold_start;
    if (!down) begin
      if (hold_phase != HOLD_IDLE) begin
        r.event_valid = 1'b1;
        if (held >= {32'd0, lim_factory}) r.event_kind = EV_FACTORY;
        else if (held >= {32'd0, lim_restart}) r.event_kind = EV_RESTART;
        else r.event_kind = EV_SHORT;
        hold_phase = HOLD_IDLE;
      end
    end else if (hold_phase == HOLD_IDLE) begin
      hold_phase = HOLD_PRESSED;
      hold_start = now;
    end else if (now < hold_start) begin
      hold_phase = HOLD_IDLE;    // clock went backwards: silent drop
    end else begin
      if (hold_phase != HOLD_FACTORY) begin
        if (held >= {32'd0, lim_factory}) hold_phase = HOLD_FACTORY;
        else if (hold_phase == HOLD_PRESSED && held >= {32'd0, lim_restart})
          hold_phase = HOLD_RESTART;
      end
      if (hold_phase == HOLD_RESTART) r.led_overlay = OV_RESTART;
      else if (hold_phase == HOLD_FACTORY) r.led_overlay = OV_FACTORY;
    end
    return r;
  endfunction

  function automatic logic [TimeW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TimeW-1:0] pick_start();
    case ($urandom_range(0, 3))
      0: return rand64();
      1: return 64'($urandom_range(0, 100000));
      2: return ~64'($urandom_range(0, 100000));   // near the top, so holds may wrap
      default: return {32'd0, $urandom};
    endcase
  endfunction

  function automatic logic [TimeW-1:0] pick_hold_len();
    logic [TimeW-1:0] r, f;
    r = {32'd0, lim_restart};
    f = {32'd0, lim_factory};
    case ($urandom_range(0, 9))
      0: return r - 1;
      1: return r;
      2: return r + 1;
      3: return f - 1;
      4: return f;
      5: return f + 1;
      6: return 64'($urandom_range(0, 200));
      7: return rand64() % (f + r + 2);
      8: return rand64() % (((f > r) ? f : r) * 2 + 2);
      default: return rand64();
    endcase
  endfunction

  task automatic queue_sample(input logic down, input logic [TimeW-1:0] stamp);
    sample_t s;
    s.down  = down;
    s.stamp = stamp;
    sample_q.push_back(s);
  endtask

  // press, a few nondecreasing hold samples, then release
  task automatic queue_press(input int unsigned holds);
    logic [TimeW-1:0] t0, len, off, cand;
    t0  = pick_start();
    len = pick_hold_len();
    off = '0;
    queue_sample(1'b1, t0);
    for (int k = 0; k < holds; k++) begin
      case ($urandom_range(0, 4))
        0: cand = {32'd0, lim_restart};
        1: cand = {32'd0, lim_restart} - 1;
        2: cand = {32'd0, lim_factory};
        3: cand = {32'd0, lim_factory} - 1;
        default: cand = (len > off) ? off + rand64() % (len - off) : off;
      endcase
      if (cand < off || cand > len) cand = off + (len - off) / 2;
      off = cand;
      queue_sample(1'b1, t0 + off);
    end
    queue_sample(1'b0, t0 + len);
  endtask

  // hold broken by a timestamp that steps back
  task automatic queue_backstep();
    logic [TimeW-1:0] t0;
    t0 = pick_start();
    queue_sample(1'b1, t0);
    if ($urandom_range(0, 1)) queue_sample(1'b1, t0 + $urandom_range(0, 20000));
    queue_sample(1'b1, t0 - $urandom_range(1, 5000));
    queue_sample(1'($urandom_range(0, 1)), t0 + $urandom_range(0, 20000));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [HoldW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_RESTART_HOLD) lim_restart = val;
    else lim_factory = val;
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 0, gap_left = 0;

  always @(posedge clk_i) begin
    logic        nv;
    logic [71:0] nd;
    sample_t     s;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (!rst_ni) begin
      nv = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) nv = 1'b0;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() > 0) begin
          s  = sample_q.pop_front();
          nv = 1'b1;
          nd = {7'd0, s.stamp, s.down};
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
            gap_left   = $urandom_range(0, 12);
          end
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
  end

  // receiver: stall pattern switching between modes
  int unsigned rx_mode = 0, rx_left = 0, rx_tick = 0;

  always @(posedge clk_i) begin
    logic nr;
    nr = 1'b0;
    if (rst_ni) begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = (rx_mode == 3) ? $urandom_range(1, 30) : $urandom_range(10, 150);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        0: nr = 1'b1;
        1: nr = 1'($urandom_range(0, 1));
        2: nr = (rx_tick % 3 == 0);
        default: nr = 1'b0;
      endcase
    end
    m_axis_tready <= nr;
  end

  // monitor: predicts on accepted input items, checks accepted result items
  always @(posedge clk_i) begin
    bhd_result_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.push_back(classify_sample(s_axis_tdata[0], s_axis_tdata[64:1]));
        n_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[4:0];
        n_out++;
        if (verdict_q.size() == 0) begin
          $display("%0t: result with nothing expected: valid %0d kind %0d overlay %0d",
                   $time, got.event_valid, got.event_kind, got.led_overlay);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (got.event_valid !== want.event_valid) begin
            $display("%0t: event_valid expected %0d got %0d", $time,
                     want.event_valid, got.event_valid);
            errors++;
          end
          if (got.event_kind !== want.event_kind) begin
            $display("%0t: event_kind expected %0d got %0d", $time,
                     want.event_kind, got.event_kind);
            errors++;
          end
          if (got.led_overlay !== want.led_overlay) begin
            $display("%0t: led_overlay expected %0d got %0d", $time,
                     want.led_overlay, got.led_overlay);
            errors++;
          end
          if (want.event_valid) begin
            if (want.event_kind == EV_SHORT) n_short++;
            else if (want.event_kind == EV_RESTART) n_restart++;
            else n_factory++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, verdict_q.size());
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: ;  // thresholds at their reset values
        1: begin write_reg(REG_RESTART_HOLD, '0); write_reg(REG_FACTORY_HOLD, '0); end
        2: begin write_reg(REG_RESTART_HOLD, '1); write_reg(REG_FACTORY_HOLD, '1); end
        3: begin  // restart above factory: factory tested first
          write_reg(REG_RESTART_HOLD, 32'd5000);
          write_reg(REG_FACTORY_HOLD, 32'd2000);
        end
        4: begin write_reg(REG_RESTART_HOLD, 32'd1); write_reg(REG_FACTORY_HOLD, 32'd2); end
        5: begin
          write_reg(REG_RESTART_HOLD, $urandom_range(0, 65535));
          write_reg(REG_FACTORY_HOLD, $urandom_range(0, 65535));
        end
        default: begin
          write_reg(REG_RESTART_HOLD, $urandom);
          write_reg(REG_FACTORY_HOLD, $urandom);
        end
      endcase
      @(negedge clk_i);

      if (p == 0) begin
        queue_sample(1'b0, 64'd0);           // release while idle
        queue_sample(1'b1, 64'd0);
        queue_sample(1'b1, 64'd2999);
        queue_sample(1'b1, 64'd3000);        // restart armed
        queue_sample(1'b1, 64'd9999);
        queue_sample(1'b1, 64'd10000);       // factory armed
        queue_sample(1'b1, 64'd20000);
        queue_sample(1'b1, 64'd15000);       // factory kept, still after start
        queue_sample(1'b0, 64'd20000);
        queue_sample(1'b1, 64'd100);
        queue_sample(1'b0, 64'd3099);
        queue_sample(1'b1, 64'd500);
        queue_sample(1'b0, 64'd3500);
        queue_sample(1'b1, 64'hFFFF_FFFF_FFFF_FFF6);
        queue_sample(1'b0, 64'd5);           // duration wraps around zero
        queue_sample(1'b1, 64'd5000);
        queue_sample(1'b1, 64'd4999);        // time goes backwards during hold
        queue_sample(1'b0, 64'd6000);
        queue_sample(1'b1, 64'd5000);
        queue_sample(1'b0, 64'd4000);        // release before start: huge duration
        queue_sample(1'b1, '1);
        queue_sample(1'b1, '1);
        queue_sample(1'b0, 64'd0);
        queue_sample(1'b1, 64'h5555_5555_5555_5555);
        queue_sample(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
      end

      while (sample_q.size() < PhaseItems) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) queue_press($urandom_range(0, 4));
        else if (pick == 7) queue_backstep();
        else queue_sample(1'($urandom_range(0, 1)), pick_start());
      end

      // sender holds off until every result of this phase has come back
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d samples and %0d results over %0d threshold settings",
             n_in, n_out, NumPhases);
    $display("releases seen: %0d short, %0d restart, %0d factory",
             n_short, n_restart, n_factory);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, verdict_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bhd_pkg.sv
src/bhd_cfg_regs.sv
src/bhd_classify.sv
src/button_hold_duration_classifier.sv
test/tb.sv
